FILE: sv/qau_pkg.sv
package qau_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int COMP_W        = 32;
  localparam int QUO_BITS      = COMP_W + FRACTION_BITS;
  localparam int ACC_W         = 2 * COMP_W + 2;
  localparam int MUL_LAT       = 3;
  localparam int ADD_LAT       = 1;
  localparam int DIV_LAT       = QUO_BITS + 2;
  localparam int TOTAL_LAT     = DIV_LAT + 2;

  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_MULVEC = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_DIV    = 3'd4
  } op_e;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic [2:0] command;
    comp_t      left_w;
    comp_t      left_x;
    comp_t      left_y;
    comp_t      left_z;
    comp_t      right_w;
    comp_t      right_x;
    comp_t      right_y;
    comp_t      right_z;
  } in_t;

  typedef struct packed {
    comp_t result_w;
    comp_t result_x;
    comp_t result_y;
    comp_t result_z;
    logic  overflowed;
    logic  divided_by_zero;
  } res_t;

  localparam comp_t COMP_MAX = comp_t'({1'b0, {(COMP_W-1){1'b1}}});
  localparam comp_t COMP_MIN = comp_t'({1'b1, {(COMP_W-1){1'b0}}});

endpackage

FILE: sv/quaternion_arithmetic_unit_core.sv
// Channel   Ports                              Transaction marked by
// command   start_i, busy_o, item_i            start_i high while busy_o is low
// result    done_o, result_o                   done_o high for one cycle
//
// Every transaction, whatever the command, takes as long as a divide from the
// accepting edge to the edge that ends its done_o cycle.
// The divider sets that length: one restoring quotient bit per stage over
// 32 + FRACTION_BITS stages, plus operand and result registers.
// A new command is taken in every cycle; busy_o never rises.
// Reset clears the valid bits of the pipeline only; the data registers are
// left as they are. The receiver cannot stall, so nothing is ever held back.
module quaternion_arithmetic_unit_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  qau_pkg::in_t  item_i,
  output logic          done_o,
  output qau_pkg::res_t result_o
);

  localparam int DL = qau_pkg::DIV_LAT;
  localparam int MD = qau_pkg::DIV_LAT - qau_pkg::MUL_LAT;
  localparam int AD = qau_pkg::DIV_LAT - qau_pkg::ADD_LAT;

  // Operand register feeding all three units in parallel.
  qau_pkg::in_t  in_q;
  logic          in_vld_q;

  qau_pkg::res_t mul_res;
  qau_pkg::res_t add_res;
  qau_pkg::res_t div_res;

  // Shorter units are delayed so all results line up with the divider.
  qau_pkg::res_t mul_dly_q [MD];
  qau_pkg::res_t add_dly_q [AD];

  // The command and valid bit travel alongside the divider's stages.
  logic [2:0] cmd_line_q [DL];
  logic       vld_line_q [DL];

  qau_pkg::res_t res_d;
  qau_pkg::res_t res_q;
  logic          done_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      for (int k = 0; k < DL; k++) begin
        vld_line_q[k] <= 1'b0;
      end
      done_q <= 1'b0;
    end else begin
      in_vld_q      <= start_i && !busy_o;
      vld_line_q[0] <= in_vld_q;
      for (int k = 1; k < DL; k++) begin
        vld_line_q[k] <= vld_line_q[k-1];
      end
      done_q <= vld_line_q[DL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= item_i;
    end
  end

  qau_mul u_mul (
    .clk_i  (clk_i),
    .item_i (in_q),
    .res_o  (mul_res)
  );

  qau_addsub u_addsub (
    .clk_i  (clk_i),
    .item_i (in_q),
    .res_o  (add_res)
  );

  qau_div u_div (
    .clk_i  (clk_i),
    .item_i (in_q),
    .res_o  (div_res)
  );

  always_ff @(posedge clk_i) begin
    cmd_line_q[0] <= in_q.command;
    for (int k = 1; k < DL; k++) begin
      cmd_line_q[k] <= cmd_line_q[k-1];
    end
    mul_dly_q[0] <= mul_res;
    for (int k = 1; k < MD; k++) begin
      mul_dly_q[k] <= mul_dly_q[k-1];
    end
    add_dly_q[0] <= add_res;
    for (int k = 1; k < AD; k++) begin
      add_dly_q[k] <= add_dly_q[k-1];
    end
  end

  // Final selection by command; unused commands give an all-zero result.
  always_comb begin
    case (cmd_line_q[DL-1])
      qau_pkg::OP_MUL, qau_pkg::OP_MULVEC: res_d = mul_dly_q[MD-1];
      qau_pkg::OP_ADD, qau_pkg::OP_SUB:    res_d = add_dly_q[AD-1];
      qau_pkg::OP_DIV:                     res_d = div_res;
      default:                             res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // A zero divisor always saturates, so it must also raise the overflow flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.divided_by_zero |-> result_o.overflowed)
    else $error("divide-by-zero reported without overflow");

  // Each accepted transaction produces its result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(qau_pkg::TOTAL_LAT) done_o)
    else $error("result strobe missing after fixed latency");

  // Only a divide command can report a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.divided_by_zero |->
      $past(cmd_line_q[DL-1]) == qau_pkg::OP_DIV)
    else $error("divide-by-zero flag on a non-divide command");

endmodule

FILE: sv/qau_addsub.sv
module qau_addsub (
  input  logic          clk_i,
  input  qau_pkg::in_t  item_i,
  output qau_pkg::res_t res_o
);

  localparam int CW = qau_pkg::COMP_W;

  logic signed [CW-1:0] lv [4];
  logic signed [CW-1:0] rv [4];
  logic signed [CW:0]   sum [4];
  logic signed [CW-1:0] sat [4];
  logic [3:0]           ovf;

  always_comb begin
    lv[0] = item_i.left_w;  lv[1] = item_i.left_x;
    lv[2] = item_i.left_y;  lv[3] = item_i.left_z;
    rv[0] = item_i.right_w; rv[1] = item_i.right_x;
    rv[2] = item_i.right_y; rv[3] = item_i.right_z;
    for (int c = 0; c < 4; c++) begin
      if (item_i.command == qau_pkg::OP_SUB) begin
        sum[c] = (CW+1)'(lv[c]) - (CW+1)'(rv[c]);
      end else begin
        sum[c] = (CW+1)'(lv[c]) + (CW+1)'(rv[c]);
      end
      // The two top bits differ only when the exact result left the range.
      ovf[c] = sum[c][CW] ^ sum[c][CW-1];
      if (ovf[c]) begin
        sat[c] = sum[c][CW] ? qau_pkg::COMP_MIN : qau_pkg::COMP_MAX;
      end else begin
        sat[c] = sum[c][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.result_w        <= sat[0];
    res_o.result_x        <= sat[1];
    res_o.result_y        <= sat[2];
    res_o.result_z        <= sat[3];
    res_o.overflowed      <= |ovf;
    res_o.divided_by_zero <= 1'b0;
  end

endmodule

FILE: sv/qau_mul.sv
module qau_mul (
  input  logic          clk_i,
  input  qau_pkg::in_t  item_i,
  output qau_pkg::res_t res_o
);

  localparam int CW = qau_pkg::COMP_W;
  localparam int PW = 2 * CW;
  localparam int AW = qau_pkg::ACC_W;
  localparam logic signed [AW-1:0] SAT_HI = AW'(qau_pkg::COMP_MAX);
  localparam logic signed [AW-1:0] SAT_LO = AW'(qau_pkg::COMP_MIN);

  logic signed [CW-1:0] rw;
  logic signed [CW-1:0] a [4][4];
  logic signed [CW-1:0] b [4][4];
  logic signed [PW-1:0] prod_q [4][4];
  logic signed [AW-1:0] sum_q [4];
  logic signed [AW-1:0] shf [4];
  logic signed [CW-1:0] sat [4];
  logic [3:0]           ovf;

  // Term operands per component; term 0 uses the right scalar part, forced to zero for OP_MULVEC.
  always_comb begin
    rw = (item_i.command == qau_pkg::OP_MULVEC) ? '0 : item_i.right_w;
    a[0][0] = item_i.left_w; b[0][0] = rw;
    a[0][1] = item_i.left_x; b[0][1] = item_i.right_x;
    a[0][2] = item_i.left_y; b[0][2] = item_i.right_y;
    a[0][3] = item_i.left_z; b[0][3] = item_i.right_z;
    a[1][0] = item_i.left_x; b[1][0] = rw;
    a[1][1] = item_i.left_w; b[1][1] = item_i.right_x;
    a[1][2] = item_i.left_y; b[1][2] = item_i.right_z;
    a[1][3] = item_i.left_z; b[1][3] = item_i.right_y;
    a[2][0] = item_i.left_y; b[2][0] = rw;
    a[2][1] = item_i.left_w; b[2][1] = item_i.right_y;
    a[2][2] = item_i.left_z; b[2][2] = item_i.right_x;
    a[2][3] = item_i.left_x; b[2][3] = item_i.right_z;
    a[3][0] = item_i.left_z; b[3][0] = rw;
    a[3][1] = item_i.left_w; b[3][1] = item_i.right_z;
    a[3][2] = item_i.left_x; b[3][2] = item_i.right_y;
    a[3][3] = item_i.left_y; b[3][3] = item_i.right_x;
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        prod_q[c][t] <= PW'(a[c][t]) * PW'(b[c][t]);
      end
    end
  end

  // The scalar part subtracts all vector terms; the others only the last.
  always_ff @(posedge clk_i) begin
    sum_q[0] <= AW'(prod_q[0][0]) - AW'(prod_q[0][1]) - AW'(prod_q[0][2])
                - AW'(prod_q[0][3]);
    for (int c = 1; c < 4; c++) begin
      sum_q[c] <= AW'(prod_q[c][0]) + AW'(prod_q[c][1]) + AW'(prod_q[c][2])
                  - AW'(prod_q[c][3]);
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      shf[c] = sum_q[c] >>> qau_pkg::FRACTION_BITS;
      ovf[c] = (shf[c] > SAT_HI) || (shf[c] < SAT_LO);
      if (shf[c] > SAT_HI) begin
        sat[c] = qau_pkg::COMP_MAX;
      end else if (shf[c] < SAT_LO) begin
        sat[c] = qau_pkg::COMP_MIN;
      end else begin
        sat[c] = shf[c][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.result_w        <= sat[0];
    res_o.result_x        <= sat[1];
    res_o.result_y        <= sat[2];
    res_o.result_z        <= sat[3];
    res_o.overflowed      <= |ovf;
    res_o.divided_by_zero <= 1'b0;
  end

endmodule

FILE: sv/qau_div.sv
module qau_div (
  input  logic          clk_i,
  input  qau_pkg::in_t  item_i,
  output qau_pkg::res_t res_o
);

  localparam int CW = qau_pkg::COMP_W;
  localparam int QB = qau_pkg::QUO_BITS;
  localparam int FB = qau_pkg::FRACTION_BITS;
  localparam logic [QB-1:0] POS_LIM = QB'(qau_pkg::COMP_MAX);
  localparam logic [QB-1:0] NEG_LIM = QB'({1'b1, {(CW-1){1'b0}}});

  logic signed [CW-1:0] lv [4];
  logic signed [CW-1:0] rv [4];
  logic [CW-1:0] mag_l [4];
  logic [CW-1:0] mag_r [4];

  // One restoring step per stage: the numerator shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  logic [QB-1:0] num_q [4][QB+1];
  logic [CW-1:0] rem_q [4][QB+1];
  logic [CW-1:0] den_q [4][QB+1];
  logic          neg_q [4][QB+1];
  logic          lneg_q [4][QB+1];
  logic          dz_q [4][QB+1];
  logic [CW:0]   trial [4][QB];
  logic          ge [4][QB];

  logic [QB-1:0]        quo [4];
  logic signed [CW-1:0] sat [4];
  logic [3:0]           ovf;
  logic [3:0]           dzv;

  always_comb begin
    lv[0] = item_i.left_w;  lv[1] = item_i.left_x;
    lv[2] = item_i.left_y;  lv[3] = item_i.left_z;
    rv[0] = item_i.right_w; rv[1] = item_i.right_x;
    rv[2] = item_i.right_y; rv[3] = item_i.right_z;
    for (int l = 0; l < 4; l++) begin
      mag_l[l] = lv[l][CW-1] ? CW'(-lv[l]) : CW'(lv[l]);
      mag_r[l] = rv[l][CW-1] ? CW'(-rv[l]) : CW'(rv[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      num_q[l][0]  <= {mag_l[l], {FB{1'b0}}};
      rem_q[l][0]  <= '0;
      den_q[l][0]  <= mag_r[l];
      neg_q[l][0]  <= lv[l][CW-1] ^ rv[l][CW-1];
      lneg_q[l][0] <= lv[l][CW-1];
      dz_q[l][0]   <= (rv[l] == '0);
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < QB; k++) begin
        trial[l][k] = {rem_q[l][k], num_q[l][k][QB-1]};
        ge[l][k]    = trial[l][k] >= {1'b0, den_q[l][k]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < QB; k++) begin
        rem_q[l][k+1]  <= ge[l][k] ? CW'(trial[l][k] - {1'b0, den_q[l][k]})
                                   : trial[l][k][CW-1:0];
        num_q[l][k+1]  <= {num_q[l][k][QB-2:0], ge[l][k]};
        den_q[l][k+1]  <= den_q[l][k];
        neg_q[l][k+1]  <= neg_q[l][k];
        lneg_q[l][k+1] <= lneg_q[l][k];
        dz_q[l][k+1]   <= dz_q[l][k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      quo[l] = num_q[l][QB];
      dzv[l] = dz_q[l][QB];
      if (dz_q[l][QB]) begin
        ovf[l] = 1'b1;
        sat[l] = lneg_q[l][QB] ? qau_pkg::COMP_MIN : qau_pkg::COMP_MAX;
      end else if (neg_q[l][QB]) begin
        ovf[l] = quo[l] > NEG_LIM;
        sat[l] = ovf[l] ? qau_pkg::COMP_MIN : CW'(-quo[l]);
      end else begin
        ovf[l] = quo[l] > POS_LIM;
        sat[l] = ovf[l] ? qau_pkg::COMP_MAX : quo[l][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.result_w        <= sat[0];
    res_o.result_x        <= sat[1];
    res_o.result_y        <= sat[2];
    res_o.result_z        <= sat[3];
    res_o.overflowed      <= |ovf;
    res_o.divided_by_zero <= |dzv;
  end

endmodule
